FILE: hdl/hio_pkg.sv
`default_nettype none
package hio_pkg;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_RAISE = 2'd2
  } op_t;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MONO_MODEL    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CRYSTAL_MODEL = 1'd1;

  localparam logic [15:0] PORT_DMA_SRC_LO  = 16'h0040;
  localparam logic [15:0] PORT_DMA_SRC_MID = 16'h0041;
  localparam logic [15:0] PORT_DMA_SRC_HI  = 16'h0042;
  localparam logic [15:0] PORT_DMA_DST_LO  = 16'h0044;
  localparam logic [15:0] PORT_DMA_DST_HI  = 16'h0045;
  localparam logic [15:0] PORT_DMA_LEN_LO  = 16'h0046;
  localparam logic [15:0] PORT_DMA_LEN_HI  = 16'h0047;
  localparam logic [15:0] PORT_DMA_CTRL    = 16'h0048;
  localparam logic [15:0] PORT_SYSTEM      = 16'h0062;
  localparam logic [15:0] PORT_HW_FLAGS    = 16'h00a0;
  localparam logic [15:0] PORT_IRQ_BASE    = 16'h00b0;
  localparam logic [15:0] PORT_IRQ_ENABLE  = 16'h00b2;
  localparam logic [15:0] PORT_IRQ_STATUS  = 16'h00b4;
  localparam logic [15:0] PORT_KEYPAD      = 16'h00b5;
  localparam logic [15:0] PORT_IRQ_ACK     = 16'h00b6;

  localparam logic [7:0] HW_FLAGS_BASE = 8'h85;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] port_addr;
    logic [7:0]  write_data;
    logic [10:0] buttons;
  } item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        dma_start;
    logic [19:0] dma_src;
    logic [15:0] dma_dst;
    logic [15:0] dma_len;
    logic        dma_mode;
  } result_t;

endpackage
`default_nettype wire

FILE: hdl/hio_core.sv
`default_nettype none
module hio_core (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [hio_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [hio_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                           fire,
  input  wire hio_pkg::item_t                 item,
  output hio_pkg::result_t                    res
);

  logic        mono_r, crystal_r;
  logic [19:0] dma_source_r, dma_source_nxt;
  logic [15:0] dma_target_r, dma_target_nxt;
  logic [15:0] dma_length_r, dma_length_nxt;
  logic        dma_enable_r, dma_enable_nxt;
  logic        dma_mode_r, dma_mode_nxt;
  logic [7:0]  irq_base_r, irq_base_nxt;
  logic [7:0]  irq_enable_r, irq_enable_nxt;
  logic [7:0]  irq_status_r, irq_status_nxt;
  logic [2:0]  keypad_groups_r, keypad_groups_nxt;
  logic [7:0]  rd;
  logic        start;
  logic [3:0]  keys;

  always_comb begin
    keys = 4'd0;
    if (keypad_groups_r[0]) keys = keys | item.buttons[3:0];
    if (keypad_groups_r[1]) keys = keys | item.buttons[7:4];
    if (keypad_groups_r[2]) keys = keys | {item.buttons[10:8], 1'b0};
  end

  always_comb begin
    dma_source_nxt    = dma_source_r;
    dma_target_nxt    = dma_target_r;
    dma_length_nxt    = dma_length_r;
    dma_enable_nxt    = dma_enable_r;
    dma_mode_nxt      = dma_mode_r;
    irq_base_nxt      = irq_base_r;
    irq_enable_nxt    = irq_enable_r;
    irq_status_nxt    = irq_status_r;
    keypad_groups_nxt = keypad_groups_r;
    rd                = 8'd0;
    start             = 1'b0;
    if (fire) begin
      case (item.op)
        hio_pkg::OP_READ: begin
          case (item.port_addr)
            hio_pkg::PORT_DMA_SRC_LO:  rd = dma_source_r[7:0];
            hio_pkg::PORT_DMA_SRC_MID: rd = dma_source_r[15:8];
            hio_pkg::PORT_DMA_SRC_HI:  rd = {4'd0, dma_source_r[19:16]};
            hio_pkg::PORT_DMA_DST_LO:  rd = dma_target_r[7:0];
            hio_pkg::PORT_DMA_DST_HI:  rd = dma_target_r[15:8];
            hio_pkg::PORT_DMA_LEN_LO:  rd = dma_length_r[7:0];
            hio_pkg::PORT_DMA_LEN_HI:  rd = dma_length_r[15:8];
            hio_pkg::PORT_DMA_CTRL:    rd = {dma_enable_r, 6'd0, dma_mode_r};
            hio_pkg::PORT_SYSTEM:      rd = {crystal_r, 7'd0};
            hio_pkg::PORT_HW_FLAGS:    rd = hio_pkg::HW_FLAGS_BASE | {6'd0, ~mono_r, 1'b0};
            hio_pkg::PORT_IRQ_BASE:    rd = mono_r ? (irq_base_r | 8'h03) : irq_base_r;
            hio_pkg::PORT_IRQ_ENABLE:  rd = irq_enable_r;
            hio_pkg::PORT_IRQ_STATUS:  rd = irq_status_r;
            hio_pkg::PORT_KEYPAD:      rd = {1'b0, keypad_groups_r, keys};
            default:                   rd = 8'd0;
          endcase
        end
        hio_pkg::OP_WRITE: begin
          case (item.port_addr)
            hio_pkg::PORT_DMA_SRC_LO:  dma_source_nxt[7:0]   = item.write_data & 8'hfe;
            hio_pkg::PORT_DMA_SRC_MID: dma_source_nxt[15:8]  = item.write_data;
            hio_pkg::PORT_DMA_SRC_HI:  dma_source_nxt[19:16] = item.write_data[3:0];
            hio_pkg::PORT_DMA_DST_LO:  dma_target_nxt[7:0]   = item.write_data & 8'hfe;
            hio_pkg::PORT_DMA_DST_HI:  dma_target_nxt[15:8]  = item.write_data;
            hio_pkg::PORT_DMA_LEN_LO:  dma_length_nxt[7:0]   = item.write_data & 8'hfe;
            hio_pkg::PORT_DMA_LEN_HI:  dma_length_nxt[15:8]  = item.write_data;
            hio_pkg::PORT_DMA_CTRL: begin
              dma_enable_nxt = item.write_data[7];
              dma_mode_nxt   = item.write_data[0];
              start          = item.write_data[7];
            end
            hio_pkg::PORT_IRQ_BASE:
              irq_base_nxt = item.write_data & (mono_r ? 8'hf8 : 8'hfe);
            hio_pkg::PORT_IRQ_ENABLE:  irq_enable_nxt    = item.write_data;
            hio_pkg::PORT_KEYPAD:      keypad_groups_nxt = item.write_data[6:4];
            hio_pkg::PORT_IRQ_ACK:     irq_status_nxt    = irq_status_r & ~item.write_data;
            default: ;
          endcase
        end
        hio_pkg::OP_RAISE: irq_status_nxt = irq_status_r | item.write_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mono_r          <= 1'b1;
      crystal_r       <= 1'b0;
      dma_source_r    <= '0;
      dma_target_r    <= '0;
      dma_length_r    <= '0;
      dma_enable_r    <= 1'b0;
      dma_mode_r      <= 1'b0;
      irq_base_r      <= '0;
      irq_enable_r    <= '0;
      irq_status_r    <= '0;
      keypad_groups_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          hio_pkg::CFG_MONO_MODEL:    mono_r    <= cfg_wdata[0];
          hio_pkg::CFG_CRYSTAL_MODEL: crystal_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      dma_source_r    <= dma_source_nxt;
      dma_target_r    <= dma_target_nxt;
      dma_length_r    <= dma_length_nxt;
      dma_enable_r    <= dma_enable_nxt;
      dma_mode_r      <= dma_mode_nxt;
      irq_base_r      <= irq_base_nxt;
      irq_enable_r    <= irq_enable_nxt;
      irq_status_r    <= irq_status_nxt;
      keypad_groups_r <= keypad_groups_nxt;
    end
  end

  always_comb begin
    res.read_data = rd;
    res.dma_start = start;
    res.dma_src   = dma_source_nxt;
    res.dma_dst   = dma_target_nxt;
    res.dma_len   = dma_length_nxt;
    res.dma_mode  = dma_mode_nxt;
  end

endmodule
`default_nettype wire

FILE: hdl/handheld_io_port_registers.sv
// I/O port register block of a handheld console CPU.
// Input channel (in_valid/in_ready): one port read, port write or interrupt
// raise per transfer, with the current keypad button states.
// Result channel (out_valid/out_ready): one result per input transfer, in
// order: read byte, DMA start pulse and the DMA settings after the access.
// Configuration: cfg_we writes cfg_wdata into register cfg_index (0 mono
// model, 1 crystal model); write only while the block is idle.
// Pipeline: an item is captured in the input register, then decoded and
// applied to the register file; its result is captured in the output
// register once the output stage is free to take it.
// Throughput: one item per cycle while the output is not stalled, set by
// the single decode stage between the input and output registers.
// Reset (rst_n low, synchronous): all port registers clear, mono model set,
// crystal model clear, both pipeline stages empty.
// Stall: while out_ready is low a pending result holds; one more item may
// wait in the input register, after which in_ready drops.
`default_nettype none
module handheld_io_port_registers (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [hio_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [hio_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [1:0]                     in_op,
  input  wire logic [15:0]                    in_port_addr,
  input  wire logic [7:0]                     in_write_data,
  input  wire logic [10:0]                    in_buttons,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [7:0]                          out_read_data,
  output logic                                out_dma_start,
  output logic [19:0]                         out_dma_src_out,
  output logic [15:0]                         out_dma_dst_out,
  output logic [15:0]                         out_dma_len_out,
  output logic                                out_dma_mode_out
);

  logic             in_valid_r;
  hio_pkg::item_t   in_item_r;
  logic             out_valid_r;
  hio_pkg::result_t out_res_r;
  hio_pkg::result_t res;
  logic             advance;

  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) in_valid_r <= in_valid;
      if (advance) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r.op         <= in_op;
      in_item_r.port_addr  <= in_port_addr;
      in_item_r.write_data <= in_write_data;
      in_item_r.buttons    <= in_buttons;
    end
    if (advance) out_res_r <= res;
  end

  hio_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .fire      (advance),
    .item      (in_item_r),
    .res       (res)
  );

  assign out_valid        = out_valid_r;
  assign out_read_data    = out_res_r.read_data;
  assign out_dma_start    = out_res_r.dma_start;
  assign out_dma_src_out  = out_res_r.dma_src;
  assign out_dma_dst_out  = out_res_r.dma_dst;
  assign out_dma_len_out  = out_res_r.dma_len;
  assign out_dma_mode_out = out_res_r.dma_mode;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input stalled with empty output stage");

  a_item_moves: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && (!out_valid_r || out_ready) |=> out_valid_r)
    else $error("pending item did not reach output stage");

  a_addr_even: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_dma_src_out[0] && !out_dma_dst_out[0] && !out_dma_len_out[0]))
    else $error("DMA address or length low bit set");

endmodule
`default_nettype wire
